FILE: design/tilt_balance_controller_top_macros.svh
// ----------------------------------------------------------------------------
// Tilt balance controller assertion macros
// Concurrent check wrappers shared by the design files; they compile away
// when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef TILT_BALANCE_CONTROLLER_TOP_MACROS_SVH
`define TILT_BALANCE_CONTROLLER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define TBC_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("tbc assertion failed");

// expression must never be true outside reset
`define TBC_ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("tbc forbidden condition seen");

`else

`define TBC_ASSERT(lbl, clk, rstn, prop)
`define TBC_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

FILE: design/tbc_pkg.sv
// ----------------------------------------------------------------------------
// Tilt balance controller package
// Shared types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tbc_pkg;

	// CORDIC angle table geometry
	localparam int ATAN_ENTRIES = 24;
	localparam int ATAN_IW      = 5;

	// Datapath widths
	localparam int ANGLE_W  = 26;  // degrees, Q16, signed
	localparam int CORDIC_W = 28;  // CORDIC x/y working width
	localparam int GYRO_W   = 25;  // gyro increment, degrees Q16, signed

	// Angle constants, degrees Q16
	localparam logic signed [ANGLE_W-1:0] DEG180_Q16   = 26'sd11796480;
	localparam logic signed [ANGLE_W-1:0] TILT_MAX_Q16 = 26'sd16711680;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_WEIGHT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_SCALE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_ANGLE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_MAX       = 3'd5;

	// Configuration reset values
	localparam logic [16:0] RST_FILTER_WEIGHT = 17'd1311;
	localparam logic [23:0] RST_GYRO_SCALE    = 24'd163930;
	localparam logic [11:0] RST_DRIVE_GAIN    = 12'd600;
	localparam logic [15:0] RST_DRIVE_LIMIT   = 16'd1280;
	localparam logic [15:0] RST_CUTOFF_ANGLE  = 16'd15360;
	localparam logic [9:0]  RST_PWM_MAX       = 10'd1023;

	// Mid queue geometry
	localparam int Q_DEPTH = 2;
	localparam int Q_PW    = 1;
	localparam int Q_CW    = 2;

	// Configuration register bank
	typedef struct packed {
		logic [16:0] filter_weight;
		logic [23:0] gyro_scale;
		logic [11:0] drive_gain;
		logic [15:0] drive_limit;
		logic [15:0] cutoff_angle;
		logic [9:0]  pwm_max;
	} cfg_t;

	// One classified measurement handed from front to back
	typedef struct packed {
		logic signed [ANGLE_W-1:0] accel;
		logic signed [GYRO_W-1:0]  gyro;
	} meas_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_RUN,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL_OLD,
		B_MUL_NEW,
		B_SAT,
		B_CLAMP,
		B_GAIN,
		B_OUT
	} back_state_t;

	// atan(2^-i) in degrees, Q16
	function automatic logic [21:0] atan_deg(input logic [ATAN_IW-1:0] idx);
		logic [21:0] v;
		case (idx)
			5'd0:    v = 22'd2949120;
			5'd1:    v = 22'd1740967;
			5'd2:    v = 22'd919879;
			5'd3:    v = 22'd466945;
			5'd4:    v = 22'd234379;
			5'd5:    v = 22'd117304;
			5'd6:    v = 22'd58666;
			5'd7:    v = 22'd29335;
			5'd8:    v = 22'd14668;
			5'd9:    v = 22'd7334;
			5'd10:   v = 22'd3667;
			5'd11:   v = 22'd1833;
			5'd12:   v = 22'd917;
			5'd13:   v = 22'd458;
			5'd14:   v = 22'd229;
			5'd15:   v = 22'd115;
			5'd16:   v = 22'd57;
			5'd17:   v = 22'd29;
			5'd18:   v = 22'd14;
			5'd19:   v = 22'd7;
			5'd20:   v = 22'd4;
			5'd21:   v = 22'd2;
			5'd22:   v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: design/tbc_front.sv
// ----------------------------------------------------------------------------
// Tilt balance controller front end
// Accepts sensor items, runs the vectoring CORDIC for the accelerometer angle
// and scales the gyro rate, then hands one measurement to the mid queue.
// ----------------------------------------------------------------------------
module tbc_front #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic signed [15:0]    accel_sine,
	input  logic signed [15:0]    accel_cosine,
	input  logic signed [15:0]    gyro_rate,
	input  logic [23:0]           gyro_scale,
	output logic                  q_push,
	input  logic                  q_full,
	output tbc_pkg::meas_t        q_data
);

	localparam int IW = tbc_pkg::ATAN_IW;
	localparam int CW = tbc_pkg::CORDIC_W;
	localparam int AW = tbc_pkg::ANGLE_W;
	localparam logic [IW-1:0] LAST_STEP = IW'(CORDIC_STEPS - 1);

	tbc_pkg::front_state_t state_q, state_d;

	logic signed [CW-1:0] x_q, y_q;
	logic signed [AW-1:0] z_q, base_q;
	logic                 zero_q;
	logic [IW-1:0]        cnt_q;
	logic signed [15:0]   gyro_q;
	logic signed [40:0]   gprod_q;

	logic                 in_fire;
	logic signed [16:0]   x_in, y_in, x_m, y_m;
	logic signed [CW-1:0] dx, dy;
	logic signed [AW-1:0] atan_step;
	logic                 y_pos;

	assign in_fire = push && !full;

	// Mirror left half-plane vectors through the origin
	assign x_in = {accel_cosine[15], accel_cosine};
	assign y_in = {accel_sine[15], accel_sine};
	assign x_m  = accel_cosine[15] ? -x_in : x_in;
	assign y_m  = accel_cosine[15] ? -y_in : y_in;

	// One CORDIC micro-rotation
	assign dx        = y_q >>> cnt_q;
	assign dy        = x_q >>> cnt_q;
	assign atan_step = {4'b0000, tbc_pkg::atan_deg(cnt_q)};
	assign y_pos     = !y_q[CW-1] && (y_q != '0);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tbc_pkg::F_IDLE: begin
				if (in_fire)
					state_d = tbc_pkg::F_RUN;
			end
			tbc_pkg::F_RUN: begin
				if (cnt_q == LAST_STEP)
					state_d = tbc_pkg::F_PUSH;
			end
			tbc_pkg::F_PUSH: begin
				if (!q_full)
					state_d = tbc_pkg::F_IDLE;
			end
			default: state_d = tbc_pkg::F_IDLE;
		endcase
	end

	// Handshake outputs
	always_comb begin
		full   = 1'b1;
		q_push = 1'b0;
		unique case (state_q)
			tbc_pkg::F_IDLE: full = 1'b0;
			tbc_pkg::F_RUN:  full = 1'b1;
			tbc_pkg::F_PUSH: q_push = 1'b1;
			default:         full = 1'b1;
		endcase
	end

	// Measurement handed to the back end
	always_comb begin
		q_data.accel = zero_q ? '0 : base_q + z_q;
		q_data.gyro  = gprod_q[40:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tbc_pkg::F_IDLE;
		else
			state_q <= state_d;
	end

	// CORDIC datapath and gyro scaling
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q    <= {{3{x_m[16]}}, x_m, 8'b0};
			y_q    <= {{3{y_m[16]}}, y_m, 8'b0};
			z_q    <= '0;
			cnt_q  <= '0;
			zero_q <= (accel_sine == 16'sd0) && (accel_cosine == 16'sd0);
			gyro_q <= gyro_rate;
			if (!accel_cosine[15])
				base_q <= '0;
			else if (accel_sine[15])
				base_q <= -tbc_pkg::DEG180_Q16;
			else
				base_q <= tbc_pkg::DEG180_Q16;
		end else if (state_q == tbc_pkg::F_RUN) begin
			cnt_q   <= cnt_q + 1'b1;
			gprod_q <= gyro_q * $signed({1'b0, gyro_scale});
			if (y_pos) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_step;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_step;
			end
		end
	end

endmodule

FILE: design/tbc_queue.sv
// ----------------------------------------------------------------------------
// Tilt balance controller mid queue
// Two-entry FIFO of measurements between the front and back ends.
// ----------------------------------------------------------------------------
`include "tilt_balance_controller_top_macros.svh"

module tbc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  tbc_pkg::meas_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output tbc_pkg::meas_t rd_data,
	output logic           empty
);

	localparam int PW = tbc_pkg::Q_PW;
	localparam int CW = tbc_pkg::Q_CW;

	tbc_pkg::meas_t mem_q [tbc_pkg::Q_DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           do_wr, do_rd;

	assign full    = (cnt_q == CW'(tbc_pkg::Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	`TBC_ASSERT(a_q_cnt_bound, clk, arst_n, cnt_q <= CW'(tbc_pkg::Q_DEPTH))
	`TBC_ASSERT_NEVER(a_q_full_empty, clk, arst_n, full && empty)
	`TBC_ASSERT_NEVER(a_q_pop_empty, clk, arst_n, rd_en && empty)

endmodule

FILE: design/tbc_back.sv
// ----------------------------------------------------------------------------
// Tilt balance controller back end
// Complementary filter update, drive computation and the result register,
// sequenced over one shared multiplier.
// ----------------------------------------------------------------------------
`include "tilt_balance_controller_top_macros.svh"

module tbc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tbc_pkg::cfg_t       cfg,
	input  logic                q_empty,
	input  tbc_pkg::meas_t      q_data,
	output logic                q_pop,
	output logic                empty,
	input  logic                pop,
	output logic [9:0]          drive_forward,
	output logic [9:0]          drive_reverse,
	output logic signed [16:0]  tilt_estimate,
	output logic                tipped_over
);

	localparam int AW = tbc_pkg::ANGLE_W;

	tbc_pkg::back_state_t state_q, state_d;

	logic signed [AW-1:0] tilt_q;
	logic signed [AW:0]   sum_q;
	logic signed [AW-1:0] accel_q;
	logic signed [45:0]   prod_q, acc_q;
	logic [23:0]          cmag_q;
	logic                 cneg_q, tip_q;
	logic [20:0]          mag_q;

	logic                 out_valid_q, out_tip_q;
	logic [9:0]           out_fwd_q, out_rev_q;
	logic signed [16:0]   out_tilt_q;

	logic [16:0]          w_eff, w_inv;
	logic [16:0]          mul_a;
	logic signed [27:0]   mul_b;
	logic signed [45:0]   mul_p;
	logic signed [45:0]   mix;
	logic signed [29:0]   mix_sh;
	logic [23:0]          tabs, lim;
	logic [9:0]           dmag;
	logic                 out_wr;

	// Weight above one acts as one
	assign w_eff = cfg.filter_weight[16] ? 17'd65536 : cfg.filter_weight;
	assign w_inv = 17'd65536 - w_eff;

	// Shared multiplier
	assign mul_p = $signed({1'b0, mul_a}) * mul_b;

	// Filter mix, back to Q16
	assign mix    = acc_q + prod_q;
	assign mix_sh = mix[45:16];

	// Tilt magnitude and drive clamp
	assign tabs = tilt_q[AW-1] ? 24'(-tilt_q) : tilt_q[23:0];
	assign lim  = {cfg.drive_limit, 8'b0};

	// Duty magnitude after cutoff and pwm clamp
	assign dmag = tip_q ? 10'd0
	            : (mag_q > {11'b0, cfg.pwm_max}) ? cfg.pwm_max : mag_q[9:0];

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tbc_pkg::B_IDLE:    if (!q_empty) state_d = tbc_pkg::B_MUL_OLD;
			tbc_pkg::B_MUL_OLD: state_d = tbc_pkg::B_MUL_NEW;
			tbc_pkg::B_MUL_NEW: state_d = tbc_pkg::B_SAT;
			tbc_pkg::B_SAT:     state_d = tbc_pkg::B_CLAMP;
			tbc_pkg::B_CLAMP:   state_d = tbc_pkg::B_GAIN;
			tbc_pkg::B_GAIN:    state_d = tbc_pkg::B_OUT;
			tbc_pkg::B_OUT:     if (!out_valid_q || pop) state_d = tbc_pkg::B_IDLE;
			default:            state_d = tbc_pkg::B_IDLE;
		endcase
	end

	// Control outputs and multiplier operand selection
	always_comb begin
		q_pop  = 1'b0;
		out_wr = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			tbc_pkg::B_IDLE: q_pop = !q_empty;
			tbc_pkg::B_MUL_OLD: begin
				mul_a = w_inv;
				mul_b = {sum_q[AW], sum_q};
			end
			tbc_pkg::B_MUL_NEW: begin
				mul_a = w_eff;
				mul_b = {{2{accel_q[AW-1]}}, accel_q};
			end
			tbc_pkg::B_GAIN: begin
				mul_a = {5'b0, cfg.drive_gain};
				mul_b = {4'b0, cmag_q};
			end
			tbc_pkg::B_OUT: out_wr = !out_valid_q || pop;
			default: q_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tbc_pkg::B_IDLE;
			tilt_q  <= '0;
		end else begin
			state_q <= state_d;
			// Saturate the filtered tilt to +-255 degrees
			if (state_q == tbc_pkg::B_SAT) begin
				if (mix_sh > 30'(tbc_pkg::TILT_MAX_Q16))
					tilt_q <= tbc_pkg::TILT_MAX_Q16;
				else if (mix_sh < -30'(tbc_pkg::TILT_MAX_Q16))
					tilt_q <= -tbc_pkg::TILT_MAX_Q16;
				else
					tilt_q <= mix_sh[AW-1:0];
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			tbc_pkg::B_IDLE: begin
				sum_q   <= {tilt_q[AW-1], tilt_q}
				         + {{2{q_data.gyro[tbc_pkg::GYRO_W-1]}}, q_data.gyro};
				accel_q <= q_data.accel;
			end
			tbc_pkg::B_MUL_OLD: prod_q <= mul_p;
			tbc_pkg::B_MUL_NEW: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			tbc_pkg::B_CLAMP: begin
				cmag_q <= (tabs > lim) ? lim : tabs;
				cneg_q <= tilt_q[AW-1];
				tip_q  <= tabs >= {cfg.cutoff_angle, 8'b0};
			end
			tbc_pkg::B_GAIN: mag_q <= mul_p[36:16];
			default: mag_q <= mag_q;
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_wr)
			out_valid_q <= 1'b1;
		else if (pop)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_wr) begin
			out_fwd_q  <= cneg_q ? 10'd0 : dmag;
			out_rev_q  <= cneg_q ? dmag : 10'd0;
			out_tilt_q <= tilt_q[24:8];
			out_tip_q  <= tip_q;
		end
	end

	assign empty         = !out_valid_q;
	assign drive_forward = out_fwd_q;
	assign drive_reverse = out_rev_q;
	assign tilt_estimate = out_tilt_q;
	assign tipped_over   = out_tip_q;

	`TBC_ASSERT(a_tilt_bound, clk, arst_n,
		(tilt_q <= tbc_pkg::TILT_MAX_Q16) && (tilt_q >= -tbc_pkg::TILT_MAX_Q16))
	`TBC_ASSERT_NEVER(a_both_dirs, clk, arst_n,
		out_valid_q && (out_fwd_q != 10'd0) && (out_rev_q != 10'd0))
	`TBC_ASSERT(a_tip_zero, clk, arst_n,
		(out_valid_q && out_tip_q) |-> (out_fwd_q == 10'd0 && out_rev_q == 10'd0))

endmodule

FILE: design/tilt_balance_controller_top.sv
// ----------------------------------------------------------------------------
// Tilt balance controller top level
// Complementary-filter tilt estimate with a proportional, sign-split drive.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive accel_sine, accel_cosine and gyro_rate with push; an
//   item is taken on a clock edge with push high and full low.
//   Result channel: while empty is low the ports carry the oldest result;
//   pop high on a clock edge takes it.
//   Configuration: cfg_valid with cfg_index and cfg_data writes one register;
//   cfg_ready is always high. Write only while the block is idle.
//   Input rate: set by the front end's CORDIC, one micro-rotation per cycle;
//   the front takes no new item until it has handed the last one on.
//   Result path: after the CORDIC the back end pops the queued item and runs
//   its six steps (two filter multiplies, saturate, clamp, gain, result write)
//   before the result shows.
//   A two-entry queue between front and back and a result register let the
//   front keep accepting while an unread result waits; when the receiver
//   stalls, the back end holds its finished item; once the queue is full the
//   front holds its own and full stays high.
//   Reset clears the tilt to zero, loads the default registers and empties
//   the queue and the result register.
// ----------------------------------------------------------------------------
module tilt_balance_controller_top #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic signed [15:0]             accel_sine,
	input  logic signed [15:0]             accel_cosine,
	input  logic signed [15:0]             gyro_rate,
	output logic                           empty,
	input  logic                           pop,
	output logic [9:0]                     drive_forward,
	output logic [9:0]                     drive_reverse,
	output logic signed [16:0]             tilt_estimate,
	output logic                           tipped_over,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tbc_pkg::CFG_DATA_W-1:0] cfg_data
);

	tbc_pkg::cfg_t  cfg_q;
	tbc_pkg::meas_t fq_data, bq_data;
	logic           fq_push, fq_full, bq_pop, bq_empty;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_weight <= tbc_pkg::RST_FILTER_WEIGHT;
			cfg_q.gyro_scale    <= tbc_pkg::RST_GYRO_SCALE;
			cfg_q.drive_gain    <= tbc_pkg::RST_DRIVE_GAIN;
			cfg_q.drive_limit   <= tbc_pkg::RST_DRIVE_LIMIT;
			cfg_q.cutoff_angle  <= tbc_pkg::RST_CUTOFF_ANGLE;
			cfg_q.pwm_max       <= tbc_pkg::RST_PWM_MAX;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tbc_pkg::REG_FILTER_WEIGHT: cfg_q.filter_weight <= cfg_data[16:0];
				tbc_pkg::REG_GYRO_SCALE:    cfg_q.gyro_scale    <= cfg_data[23:0];
				tbc_pkg::REG_DRIVE_GAIN:    cfg_q.drive_gain    <= cfg_data[11:0];
				tbc_pkg::REG_DRIVE_LIMIT:   cfg_q.drive_limit   <= cfg_data[15:0];
				tbc_pkg::REG_CUTOFF_ANGLE:  cfg_q.cutoff_angle  <= cfg_data[15:0];
				tbc_pkg::REG_PWM_MAX:       cfg_q.pwm_max       <= cfg_data[9:0];
				default:                    cfg_q               <= cfg_q;
			endcase
		end
	end

	tbc_front #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.accel_sine   (accel_sine),
		.accel_cosine (accel_cosine),
		.gyro_rate    (gyro_rate),
		.gyro_scale   (cfg_q.gyro_scale),
		.q_push       (fq_push),
		.q_full       (fq_full),
		.q_data       (fq_data)
	);

	tbc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fq_push),
		.wr_data (fq_data),
		.full    (fq_full),
		.rd_en   (bq_pop),
		.rd_data (bq_data),
		.empty   (bq_empty)
	);

	tbc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_empty       (bq_empty),
		.q_data        (bq_data),
		.q_pop         (bq_pop),
		.empty         (empty),
		.pop           (pop),
		.drive_forward (drive_forward),
		.drive_reverse (drive_reverse),
		.tilt_estimate (tilt_estimate),
		.tipped_over   (tipped_over)
	);

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt balance controller testbench
// Sends accelerometer and gyro items through the queue-style input, predicts
// each CORDIC angle, filtered tilt and split drive, and checks every result
// item in order. Idle bursts on both ports, a long receiver hold that fills
// the block, and configuration sweeps that include the register extremes.
// ----------------------------------------------------------------------------
module testbench;

	// One result item as the block presents it
	typedef struct packed {
		logic [9:0]         fwd;
		logic [9:0]         rev;
		logic signed [16:0] tilt;
		logic               tipped;
	} drive_result_t;

	localparam int     ROT_STEPS    = 16;
	localparam longint HALF_TURN    = 64'sd11796480;  // 180 deg, Q16
	localparam longint TILT_CEILING = 64'sd16711680;  // 255 deg, Q16
	localparam longint UNIT_WEIGHT  = 64'sd65536;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 push;
	logic                                 full;
	logic signed [15:0]                   accel_sine;
	logic signed [15:0]                   accel_cosine;
	logic signed [15:0]                   gyro_rate;
	logic                                 empty;
	logic                                 pop;
	logic [9:0]                           drive_forward;
	logic [9:0]                           drive_reverse;
	logic signed [16:0]                   tilt_estimate;
	logic                                 tipped_over;
	logic                                 cfg_valid;
	logic                                 cfg_ready;
	logic [tbc_pkg::CFG_IDX_W-1:0]        cfg_index;
	logic [tbc_pkg::CFG_DATA_W-1:0]       cfg_data;

	// Predictor state and register copies
	longint tilt_q16;
	longint weight_cfg, gyro_scale_cfg, gain_cfg, limit_cfg, cutoff_cfg, pwm_max_cfg;

	drive_result_t expected_drive[$];
	drive_result_t head_drive;
	int            errors;
	bit            calm;       // no idling on either side
	int            hold_left;  // long receiver hold, in cycles
	int            pause_left;

	tilt_balance_controller_top dut (.*);

	// Clock, 4 ns period
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("[tilt_balance_controller_top] ERROR");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (errors < 30)
			$display("%0t mismatch: %s", $realtime, msg);
		errors++;
	endtask

	// atan(2^-i) in degrees, Q16
	function automatic longint rotation_angle(input int i);
		case (i)
			0:       return 2949120;
			1:       return 1740967;
			2:       return 919879;
			3:       return 466945;
			4:       return 234379;
			5:       return 117304;
			6:       return 58666;
			7:       return 29335;
			8:       return 14668;
			9:       return 7334;
			10:      return 3667;
			11:      return 1833;
			12:      return 917;
			13:      return 458;
			14:      return 229;
			15:      return 115;
			default: return 0;
		endcase
	endfunction

	function automatic void reset_predictor();
		tilt_q16       = 0;
		weight_cfg     = tbc_pkg::RST_FILTER_WEIGHT;
		gyro_scale_cfg = tbc_pkg::RST_GYRO_SCALE;
		gain_cfg       = tbc_pkg::RST_DRIVE_GAIN;
		limit_cfg      = tbc_pkg::RST_DRIVE_LIMIT;
		cutoff_cfg     = tbc_pkg::RST_CUTOFF_ANGLE;
		pwm_max_cfg    = tbc_pkg::RST_PWM_MAX;
	endfunction

	function automatic void apply_reg(input logic [tbc_pkg::CFG_IDX_W-1:0] idx,
			input logic [tbc_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			tbc_pkg::REG_FILTER_WEIGHT: weight_cfg     = val[16:0];
			tbc_pkg::REG_GYRO_SCALE:    gyro_scale_cfg = val[23:0];
			tbc_pkg::REG_DRIVE_GAIN:    gain_cfg       = val[11:0];
			tbc_pkg::REG_DRIVE_LIMIT:   limit_cfg      = val[15:0];
			tbc_pkg::REG_CUTOFF_ANGLE:  cutoff_cfg     = val[15:0];
			tbc_pkg::REG_PWM_MAX:       pwm_max_cfg    = val[9:0];
			default: ;
		endcase
	endfunction

	// Filter one sample into the tilt and derive the drive split
	function automatic drive_result_t advance_tilt(input logic signed [15:0] ys,
			input logic signed [15:0] xc, input logic signed [15:0] gr);
		longint        y, x, z, base, dx, dy, w, sum, t, lim, c, mag, drive;
		drive_result_t r;
		y    = ys;
		x    = xc;
		z    = 0;
		base = 0;
		// vectoring CORDIC; zero vector gives zero, left half plane mirrored
		if (x != 0 || y != 0) begin
			if (x < 0) begin
				base = (y >= 0) ? HALF_TURN : -HALF_TURN;
				x = -x;
				y = -y;
			end
			x = x * 256;
			y = y * 256;
			for (int i = 0; i < ROT_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y > 0) begin
					x = x + dx;
					y = y - dy;
					z = z + rotation_angle(i);
				end else begin
					x = x - dx;
					y = y + dy;
					z = z - rotation_angle(i);
				end
			end
		end
		z = base + z;

		// complementary filter, weight capped at one
		w   = (weight_cfg > UNIT_WEIGHT) ? UNIT_WEIGHT : weight_cfg;
		sum = tilt_q16 + ((longint'(gr) * gyro_scale_cfg) >>> 16);
		t   = ((UNIT_WEIGHT - w) * sum + w * z) >>> 16;
		if (t > TILT_CEILING)
			t = TILT_CEILING;
		if (t < -TILT_CEILING)
			t = -TILT_CEILING;
		tilt_q16 = t;

		// clamp, gain truncated toward zero, cutoff, duty limit
		lim = limit_cfg * 256;
		c   = t;
		if (c > lim)
			c = lim;
		if (c < -lim)
			c = -lim;
		mag   = ((c < 0 ? -c : c) * gain_cfg) >>> 16;
		drive = (c < 0) ? -mag : mag;
		r.tipped = ((t < 0 ? -t : t) >= cutoff_cfg * 256);
		if (r.tipped)
			drive = 0;
		if (drive > pwm_max_cfg)
			drive = pwm_max_cfg;
		if (drive < -pwm_max_cfg)
			drive = -pwm_max_cfg;
		r.fwd  = (drive > 0) ? 10'(drive) : 10'd0;
		r.rev  = (drive < 0) ? 10'(-drive) : 10'd0;
		r.tilt = 17'(t >>> 8);
		return r;
	endfunction

	// Offer one item; push is left high for a back-to-back item
	task automatic send_item(input logic signed [15:0] ys, input logic signed [15:0] xc,
			input logic signed [15:0] gr);
		if (!calm && $urandom_range(0, 5) == 0) begin
			push = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		push         = 1'b1;
		accel_sine   = ys;
		accel_cosine = xc;
		gyro_rate    = gr;
		do
			@(posedge clk);
		while (full);
		expected_drive.push_back(advance_tilt(ys, xc, gr));
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [tbc_pkg::CFG_IDX_W-1:0] idx,
			input logic [tbc_pkg::CFG_DATA_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do
			@(posedge clk);
		while (!cfg_ready);
		apply_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_settings(input int unsigned fw, input int unsigned gs,
			input int unsigned gn, input int unsigned lm, input int unsigned co,
			input int unsigned pm);
		write_reg(tbc_pkg::REG_FILTER_WEIGHT, 24'(fw));
		write_reg(tbc_pkg::REG_GYRO_SCALE, 24'(gs));
		write_reg(tbc_pkg::REG_DRIVE_GAIN, 24'(gn));
		write_reg(tbc_pkg::REG_DRIVE_LIMIT, 24'(lm));
		write_reg(tbc_pkg::REG_CUTOFF_ANGLE, 24'(co));
		write_reg(tbc_pkg::REG_PWM_MAX, 24'(pm));
	endtask

	// Stop offering, let every expected item arrive, then settle
	task automatic wait_idle();
		push = 1'b0;
		while (expected_drive.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic send_random_item();
		logic signed [15:0] ys, xc, gr;
		logic signed [15:0] corners [5];
		corners = '{16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sh7fff};
		ys = $urandom;
		xc = $urandom;
		gr = $urandom;
		case ($urandom_range(0, 3))
			0: ;  // full range
			1: begin
				ys = $urandom_range(0, 6000) - 3000;
				xc = $urandom_range(0, 6000) - 3000;
				gr = $urandom_range(0, 600) - 300;
			end
			2: begin
				ys = corners[$urandom_range(0, 4)];
				xc = corners[$urandom_range(0, 4)];
				gr = corners[$urandom_range(0, 4)];
			end
			default: begin
				ys = $urandom_range(0, 8) - 4;
				xc = $urandom_range(0, 8) - 4;
			end
		endcase
		send_item(ys, xc, gr);
	endtask

	task automatic load_random_settings();
		int unsigned fw, gs;
		case ($urandom_range(0, 3))
			0:       fw = 0;
			1:       fw = 65536;
			2:       fw = $urandom_range(0, 131071);
			default: fw = $urandom_range(0, 4000);
		endcase
		gs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hffffff)
				: $urandom_range(0, 400000);
		load_settings(fw, gs, $urandom_range(0, 4095), $urandom_range(0, 65535),
				$urandom_range(0, 65535), $urandom_range(0, 1023));
	endtask

	// Reset values: zero vector, half-turn cases and field extremes
	task automatic test_directed();
		send_item(16'sd0, 16'sd0, 16'sd0);
		send_item(16'sd0, -16'sd5, 16'sd0);
		send_item(-16'sd3, -16'sd5, 16'sd0);
		send_item(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_item(16'sh8000, 16'sh8000, 16'sh8000);
		send_item(16'sh8000, 16'sh7fff, 16'sd0);
		send_item(16'sh7fff, 16'sh8000, -16'sd1);
		send_item(16'sd1, 16'sd0, 16'sd1);
		send_item(-16'sd1, 16'sd0, -16'sd1);
		send_item(16'sd0, 16'sh7fff, 16'sd0);
		send_item(16'sd0, 16'sh8000, 16'sd0);
		send_item(16'sd100, -16'sd100, 16'sd5000);
		wait_idle();
	endtask

	// Register extremes: zero cutoff, weight above one, saturation, duty limit
	task automatic test_register_extremes();
		load_settings(0, 0, 0, 0, 0, 0);
		send_item(16'sh7fff, 16'sd0, 16'sh7fff);
		send_item(16'sh8000, -16'sd1, 16'sh8000);
		send_item(16'sd0, 16'sh8000, 16'sd0);
		wait_idle();
		load_settings(131071, 24'hffffff, 4095, 65535, 65535, 1023);
		send_item(16'sh7fff, 16'sd1, 16'sh7fff);
		send_item(16'sh8000, 16'sd1, 16'sh8000);
		send_item(16'sd0, 16'sh8000, 16'sd0);
		wait_idle();
		load_settings(0, 24'hffffff, 4095, 65535, 65535, 1023);
		send_item(16'sd0, 16'sd0, 16'sh7fff);
		send_item(16'sd0, 16'sd0, 16'sh7fff);
		send_item(16'sd0, 16'sd0, 16'sh8000);
		wait_idle();
		load_settings(65536, 1, 1000, 100, 20000, 300);
		send_item(16'sd500, 16'sd1000, 16'sd0);
		send_item(-16'sd500, 16'sd1000, 16'sd0);
		send_item(16'sd3, 16'sd30000, 16'sd0);
		wait_idle();
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 5; phase++) begin
			load_random_settings();
			repeat (150) send_random_item();
			wait_idle();
		end
	endtask

	// Receiver holds off long enough for the block to fill and raise full
	task automatic test_backpressure();
		load_settings(tbc_pkg::RST_FILTER_WEIGHT, tbc_pkg::RST_GYRO_SCALE,
				tbc_pkg::RST_DRIVE_GAIN, tbc_pkg::RST_DRIVE_LIMIT,
				tbc_pkg::RST_CUTOFF_ANGLE, tbc_pkg::RST_PWM_MAX);
		hold_left = 300;
		repeat (40) send_random_item();
		wait_idle();
	endtask

	task automatic test_steady();
		calm = 1'b1;
		load_random_settings();
		repeat (100) send_random_item();
	endtask

	// Receiver: random stall bursts, long hold on request
	initial begin
		pop        = 1'b0;
		pause_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				pop = 1'b0;
				hold_left--;
			end else if (pause_left > 0) begin
				pop = 1'b0;
				pause_left--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				pop        = 1'b0;
				pause_left = $urandom_range(1, 19) - 1;
			end else begin
				pop = 1'b1;
			end
		end
	end

	// Compare each popped item with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_drive.size() == 0) begin
				report_mismatch("result item with none expected");
			end else begin
				head_drive = expected_drive.pop_front();
				if (drive_forward !== head_drive.fwd)
					report_mismatch($sformatf("drive_forward %0d, expected %0d",
							drive_forward, head_drive.fwd));
				if (drive_reverse !== head_drive.rev)
					report_mismatch($sformatf("drive_reverse %0d, expected %0d",
							drive_reverse, head_drive.rev));
				if (tilt_estimate !== head_drive.tilt)
					report_mismatch($sformatf("tilt_estimate %0d, expected %0d",
							tilt_estimate, head_drive.tilt));
				if (tipped_over !== head_drive.tipped)
					report_mismatch($sformatf("tipped_over %0b, expected %0b",
							tipped_over, head_drive.tipped));
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		push         = 1'b0;
		accel_sine   = '0;
		accel_cosine = '0;
		gyro_rate    = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		calm         = 1'b0;
		hold_left    = 0;
		errors       = 0;
		reset_predictor();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_register_extremes();
		test_random();
		test_backpressure();
		test_steady();
		wait_idle();

		if (errors == 0)
			$display("[tilt_balance_controller_top] OK");
		else
			$display("[tilt_balance_controller_top] ERROR");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+design
design/tbc_pkg.sv
design/tbc_front.sv
design/tbc_queue.sv
design/tbc_back.sv
design/tilt_balance_controller_top.sv
verif/testbench.sv
